// ===== hdl/lcmas_pkg.sv =====
// Shared widths, types and register codes of the load cell moving average scaler.
package lcmas_pkg;

    // Window length; must be a power of two so the mean is a shift.
    localparam int AVG_LEN     = 8;
    localparam int AVG_SH      = $clog2(AVG_LEN);
    localparam int PTR_W       = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;

    localparam int SAMPLE_W    = 24;
    localparam int SUM_W       = 30;
    localparam int MASS_W      = 32;
    localparam int FORCE_W     = 36;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int FRAC_W      = 8;
    localparam int GRAV_FRAC_W = 12;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [MASS_W-1:0]   t_mass;
    typedef logic signed [FORCE_W-1:0]  t_force;
    typedef logic [CFG_W-1:0]           t_cfg_data;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_WEIGHT = 1'b0,
        REG_NEWTONS    = 1'b1
    } t_cfg_reg;

    localparam t_cfg_data CAL_WEIGHT_RST = 16'd1;
    localparam t_cfg_data NEWTONS_RST    = 16'd40182;

endpackage

// ===== hdl/lcmas_if.sv =====
// Valid/ready channel interfaces for samples and scaled results.
interface lcmas_sample_if;
    logic                 valid;
    logic                 ready;
    lcmas_pkg::t_sample   sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface lcmas_result_if;
    logic                 valid;
    logic                 ready;
    lcmas_pkg::t_sample   average;
    lcmas_pkg::t_mass     mass;
    lcmas_pkg::t_force    force_res;

    modport source (output valid, output average, output mass, output force_res, input ready);
    modport sink   (input valid, input average, input mass, input force_res, output ready);
endinterface

// ===== hdl/load_cell_moving_average_scaler.sv =====
// Boxcar moving average of load cell samples with mass and force scaling.
//
// Usage:
//   i_sample_ch carries one signed 24-bit sample per item; o_result_ch
//   carries average, mass (Q.8) and force_res (Q.8) per item. Both use
//   valid/ready; an item moves on a clock edge with valid and ready high.
//   The config port writes calibration_weight (index 0) or newtons_per_kg
//   (index 1) on any edge with i_cfg_we high; write only while idle.
// Sequence:
//   A sample is accepted only in the idle state, so the block finishes
//   one sample before it takes the next. The mass comes from a restoring
//   divider (one quotient bit per cycle) and the force from a shift-add
//   multiplier (one factor bit per cycle).
// Reset:
//   Synchronous active-low i_rst_n zeroes the window and running sum and
//   loads the default register values.
// Stall:
//   The result sits in an output register; the next sample is accepted
//   and processed while it waits, and the block holds before loading a
//   new result until the receiver has taken the previous one.
module load_cell_moving_average_scaler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lcmas_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  lcmas_pkg::t_cfg_data           i_cfg_data,
    lcmas_sample_if.sink                   i_sample_ch,
    lcmas_result_if.source                 o_result_ch
);

    localparam int DIVD_W  = lcmas_pkg::SAMPLE_W + lcmas_pkg::FRAC_W;
    localparam int CNT_W   = $clog2(DIVD_W);
    localparam int HI_W    = lcmas_pkg::MASS_W + 2;
    localparam int ACC_W   = HI_W + lcmas_pkg::CFG_W;
    localparam int PROD_W  = lcmas_pkg::MASS_W + lcmas_pkg::CFG_W;
    localparam int CFG_W   = lcmas_pkg::CFG_W;
    localparam int SUM_W   = lcmas_pkg::SUM_W;
    localparam int SAMPLE_W = lcmas_pkg::SAMPLE_W;
    localparam int MASS_W  = lcmas_pkg::MASS_W;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_ADD  = 8'b0000_0010,
        ST_AVG  = 8'b0000_0100,
        ST_LOAD = 8'b0000_1000,
        ST_DIV  = 8'b0001_0000,
        ST_SIGN = 8'b0010_0000,
        ST_MUL  = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } t_state;

    t_state                         r_state, n_state;
    lcmas_pkg::t_sample             r_window [lcmas_pkg::AVG_LEN];
    logic [lcmas_pkg::PTR_W-1:0]    r_ptr;
    logic signed [SUM_W-1:0]        r_sum;
    lcmas_pkg::t_sample             r_samp;
    lcmas_pkg::t_sample             r_avg;
    logic                           r_neg;
    logic [CFG_W-1:0]               r_rem;
    logic [DIVD_W-1:0]              r_quo;
    logic [CNT_W-1:0]               r_cnt;
    lcmas_pkg::t_mass               r_mass;
    logic [ACC_W-1:0]               r_acc;
    lcmas_pkg::t_cfg_data           r_cal;
    lcmas_pkg::t_cfg_data           r_npk;
    logic                           r_out_valid;
    lcmas_pkg::t_sample             r_out_avg;
    lcmas_pkg::t_mass               r_out_mass;
    lcmas_pkg::t_force              r_out_force;

    logic                           in_take;
    logic                           out_free;
    lcmas_pkg::t_sample             old_entry;
    logic signed [SUM_W-1:0]        old_ext;
    logic signed [SUM_W-1:0]        samp_ext;
    logic signed [SUM_W-1:0]        sum_biased;
    logic signed [SUM_W-1:0]        avg_full;
    lcmas_pkg::t_sample             avg_sat;
    logic [SAMPLE_W-1:0]            avg_mag;
    lcmas_pkg::t_cfg_data           divisor;
    logic [CFG_W:0]                 rem_shift;
    logic [CFG_W+1:0]               rem_diff;
    logic                           rem_fits;
    logic signed [MASS_W:0]         mass_full;
    lcmas_pkg::t_mass               mass_sat;
    logic signed [HI_W-1:0]         mass_ext;
    logic signed [HI_W-1:0]         hi_sum;
    logic                           div_last;
    logic                           mul_last;

    assign in_take  = i_sample_ch.valid && i_sample_ch.ready;
    assign out_free = !r_out_valid || o_result_ch.ready;
    assign i_sample_ch.ready = (r_state == ST_IDLE);

    assign o_result_ch.valid     = r_out_valid;
    assign o_result_ch.average   = r_out_avg;
    assign o_result_ch.mass      = r_out_mass;
    assign o_result_ch.force_res = r_out_force;

    // Running sum update operands
    assign old_entry = r_window[r_ptr];
    assign old_ext   = {{(SUM_W-SAMPLE_W){old_entry[SAMPLE_W-1]}}, old_entry};
    assign samp_ext  = {{(SUM_W-SAMPLE_W){r_samp[SAMPLE_W-1]}}, r_samp};

    // Mean truncated toward zero: bias negative sums before the shift
    always_comb begin
        sum_biased = r_sum + (r_sum[SUM_W-1] ? SUM_W'(lcmas_pkg::AVG_LEN - 1) : SUM_W'(0));
        avg_full   = sum_biased >>> lcmas_pkg::AVG_SH;
        if (!avg_full[SUM_W-1] && (|avg_full[SUM_W-2:SAMPLE_W-1])) begin
            avg_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (avg_full[SUM_W-1] && !(&avg_full[SUM_W-2:SAMPLE_W-1])) begin
            avg_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            avg_sat = avg_full[SAMPLE_W-1:0];
        end
    end

    assign avg_mag = r_avg[SAMPLE_W-1] ? (~r_avg + SAMPLE_W'(1)) : r_avg;
    assign divisor = (r_cal == '0) ? CFG_W'(1) : r_cal;

    // One restoring division step
    assign rem_shift = {r_rem, r_quo[DIVD_W-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, divisor};
    assign rem_fits  = !rem_diff[CFG_W+1];

    // Apply sign to the quotient and clamp to the mass range
    always_comb begin
        mass_full = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        if (!mass_full[MASS_W] && mass_full[MASS_W-1]) begin
            mass_sat = {1'b0, {(MASS_W-1){1'b1}}};
        end else if (mass_full[MASS_W] && !mass_full[MASS_W-1]) begin
            mass_sat = {1'b1, {(MASS_W-1){1'b0}}};
        end else begin
            mass_sat = mass_full[MASS_W-1:0];
        end
    end

    // One shift-add multiply step, factor bit taken from the low end
    assign mass_ext = {{(HI_W-MASS_W){r_mass[MASS_W-1]}}, r_mass};
    assign hi_sum   = $signed(r_acc[ACC_W-1:CFG_W]) + (r_acc[0] ? mass_ext : HI_W'(0));

    assign div_last = (r_cnt == CNT_W'(DIVD_W - 1));
    assign mul_last = (r_cnt == CNT_W'(CFG_W - 1));

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_take) n_state = ST_ADD;
            ST_ADD:  n_state = ST_AVG;
            ST_AVG:  n_state = ST_LOAD;
            ST_LOAD: n_state = ST_DIV;
            ST_DIV:  if (div_last) n_state = ST_SIGN;
            ST_SIGN: n_state = ST_MUL;
            ST_MUL:  if (mul_last) n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ptr       <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_cal       <= lcmas_pkg::CAL_WEIGHT_RST;
            r_npk       <= lcmas_pkg::NEWTONS_RST;
            for (int i = 0; i < lcmas_pkg::AVG_LEN; i++) begin
                r_window[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            // Register writes
            if (i_cfg_we) begin
                case (lcmas_pkg::t_cfg_reg'(i_cfg_idx))
                    lcmas_pkg::REG_CAL_WEIGHT: r_cal <= i_cfg_data;
                    lcmas_pkg::REG_NEWTONS:    r_npk <= i_cfg_data;
                    default: ;
                endcase
            end

            // Drop the oldest entry, store the new sample
            if (r_state == ST_IDLE && in_take) begin
                r_sum           <= r_sum - old_ext;
                r_window[r_ptr] <= i_sample_ch.sample;
            end

            // Add the new sample and advance the pointer
            if (r_state == ST_ADD) begin
                r_sum <= r_sum + samp_ext;
                r_ptr <= (r_ptr == lcmas_pkg::PTR_W'(lcmas_pkg::AVG_LEN - 1)) ?
                         '0 : r_ptr + lcmas_pkg::PTR_W'(1);
            end

            // Step counter for divider and multiplier
            if (r_state == ST_LOAD || r_state == ST_SIGN) begin
                r_cnt <= '0;
            end else if (r_state == ST_DIV || r_state == ST_MUL) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            // Output register
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: if (in_take) r_samp <= i_sample_ch.sample;
            ST_AVG:  r_avg <= avg_sat;
            ST_LOAD: begin
                r_neg <= r_avg[SAMPLE_W-1];
                r_rem <= '0;
                r_quo <= {avg_mag, {lcmas_pkg::FRAC_W{1'b0}}};
            end
            ST_DIV: begin
                r_rem <= rem_fits ? rem_diff[CFG_W-1:0] : rem_shift[CFG_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], rem_fits};
            end
            ST_SIGN: begin
                r_mass <= mass_sat;
                r_acc  <= {{HI_W{1'b0}}, r_npk};
            end
            ST_MUL:  r_acc <= {hi_sum[HI_W-1], hi_sum, r_acc[CFG_W-1:1]};
            ST_DONE: begin
                if (out_free) begin
                    r_out_avg   <= r_avg;
                    r_out_mass  <= r_mass;
                    r_out_force <= r_acc[PROD_W-1:lcmas_pkg::GRAV_FRAC_W];
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== dv/tb_load_cell_moving_average_scaler.sv =====
// Self-checking testbench for the load cell moving average scaler: directed table, then random phases.
`timescale 1ns / 100ps

module tb_load_cell_moving_average_scaler;

    // One scaled result: window mean, mass and force
    typedef struct packed {
        lcmas_pkg::t_sample average;
        lcmas_pkg::t_mass   mass;
        lcmas_pkg::t_force  force_res;
    } t_scaled;

    typedef enum bit {
        ROW_CFG,
        ROW_SAMPLE
    } t_row_kind;

    // One line of the directed table
    typedef struct {
        t_row_kind            kind;
        lcmas_pkg::t_cfg_reg  reg_idx;
        lcmas_pkg::t_cfg_data reg_val;
        lcmas_pkg::t_sample   sample;
        bit                   typed;
        t_scaled              typed_res;
    } t_stim_row;

    localparam int RX_HOLD_AT     = 300;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int SETTLE_CYCLES  = 60;
    localparam int N_PHASES       = 10;
    localparam int PHASE_ITEMS    = 93;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    lcmas_pkg::t_cfg_reg  cfg_idx;
    lcmas_pkg::t_cfg_data cfg_data;

    lcmas_sample_if smp_ch ();
    lcmas_result_if res_ch ();

    load_cell_moving_average_scaler u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_sample_ch (smp_ch),
        .o_result_ch (res_ch)
    );

    // Predictor state: window, running sum, oldest slot and register copies
    longint    win_buf [lcmas_pkg::AVG_LEN];
    longint    win_sum;
    int        win_ptr;
    int        cal_weight_q;
    int        newtons_q;

    t_scaled   pending_scaled [$];
    t_stim_row stim_table [$];
    bit        no_idle;
    int        n_accepted;
    int        n_checked;
    int        n_errors;
    int        n_writes;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        #20_000_000;
        $display("%0t timeout: %0d results still pending", $time, pending_scaled.size());
        $display("FAILED: results differ");
        $finish;
    end

    function automatic longint sat_to(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Advance the window by one sample and compute mean, mass and force
    function automatic t_scaled scale_sample(input lcmas_pkg::t_sample s);
        t_scaled res;
        longint  avg;
        longint  mass;
        longint  divisor;
        longint  gravity;
        longint  force_v;
        win_sum = win_sum - win_buf[win_ptr] + longint'(s);
        win_buf[win_ptr] = longint'(s);
        win_ptr = (win_ptr == lcmas_pkg::AVG_LEN - 1) ? 0 : win_ptr + 1;
        avg = sat_to(win_sum / lcmas_pkg::AVG_LEN, lcmas_pkg::SAMPLE_W);
        divisor = (cal_weight_q == 0) ? longint'(1) : longint'(cal_weight_q);
        mass = sat_to((avg * 256) / divisor, lcmas_pkg::MASS_W);
        gravity = longint'(newtons_q);
        force_v = sat_to((mass * gravity) >>> lcmas_pkg::GRAV_FRAC_W, lcmas_pkg::FORCE_W);
        res.average   = avg[lcmas_pkg::SAMPLE_W-1:0];
        res.mass      = mass[lcmas_pkg::MASS_W-1:0];
        res.force_res = force_v[lcmas_pkg::FORCE_W-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int k;
        if (no_idle) return 0;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 90) return $urandom_range(1, 4);
        if (k < 98) return $urandom_range(5, 20);
        return $urandom_range(40, 120);
    endfunction

    function automatic lcmas_pkg::t_sample random_sample();
        logic [31:0] r;
        int          k;
        int          off;
        k = $urandom_range(0, 9);
        r = $urandom;
        off = $urandom_range(0, 255);
        if (k < 6) return r[lcmas_pkg::SAMPLE_W-1:0];
        if (k == 6) return lcmas_pkg::t_sample'(24'sh7FFFFF - off);
        if (k == 7) return lcmas_pkg::t_sample'(24'sh800000 + off);
        off = $urandom_range(0, 2000) - 1000;
        return lcmas_pkg::t_sample'(off);
    endfunction

    function automatic void cfg_row(input lcmas_pkg::t_cfg_reg r,
                                    input lcmas_pkg::t_cfg_data v);
        t_stim_row row;
        row = '{kind: ROW_CFG, reg_idx: r, reg_val: v, sample: '0, typed: 1'b0,
                typed_res: '0};
        stim_table.push_back(row);
    endfunction

    function automatic void smp_row(input lcmas_pkg::t_sample s, input bit typed,
                                    input lcmas_pkg::t_sample a,
                                    input lcmas_pkg::t_mass m, input lcmas_pkg::t_force f);
        t_stim_row row;
        row = '{kind: ROW_SAMPLE, reg_idx: lcmas_pkg::REG_CAL_WEIGHT, reg_val: '0, sample: s,
                typed: typed, typed_res: '{average: a, mass: m, force_res: f}};
        stim_table.push_back(row);
    endfunction

    // Directed table: expected values typed in where they are obvious
    function automatic void build_table();
        // window still all zero after reset
        smp_row(24'sd0, 1'b1, 24'sd0, 32'sd0, 36'sd0);
        smp_row(24'sd8, 1'b1, 24'sd1, 32'sd256, 36'sd2511);
        // negative force rounds toward minus infinity
        smp_row(-24'sd16, 1'b1, -24'sd1, -32'sd256, -36'sd2512);
        // zero calibration weight acts as one
        cfg_row(lcmas_pkg::REG_CAL_WEIGHT, 16'd0);
        smp_row(24'sd0, 1'b1, -24'sd1, -32'sd256, -36'sd2512);
        // fill the window with the largest sample, gravity off
        cfg_row(lcmas_pkg::REG_NEWTONS, 16'd0);
        repeat (7) smp_row(24'sh7FFFFF, 1'b0, '0, '0, '0);
        smp_row(24'sh7FFFFF, 1'b1, 24'sh7FFFFF, 32'sh7FFFFF00, 36'sd0);
        // fill with the smallest sample, largest gravity factor
        cfg_row(lcmas_pkg::REG_NEWTONS, 16'hFFFF);
        repeat (7) smp_row(24'sh800000, 1'b0, '0, '0, '0);
        smp_row(24'sh800000, 1'b1, 24'sh800000, 32'sh80000000, -36'sd34359214080);
        // largest divisor
        cfg_row(lcmas_pkg::REG_CAL_WEIGHT, 16'hFFFF);
        smp_row(24'sh800000, 1'b0, '0, '0, '0);
        smp_row(24'sh7FFFFF, 1'b0, '0, '0, '0);
        // odd divisor and smallest nonzero gravity factor
        cfg_row(lcmas_pkg::REG_CAL_WEIGHT, 16'd3);
        cfg_row(lcmas_pkg::REG_NEWTONS, 16'd1);
        smp_row(-24'sd1, 1'b0, '0, '0, '0);
        smp_row(24'sd1, 1'b0, '0, '0, '0);
        smp_row(24'sd5, 1'b0, '0, '0, '0);
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic push_sample(input lcmas_pkg::t_sample s, input bit typed,
                               input t_scaled typed_res);
        int      gap;
        t_scaled pred;
        gap = pick_gap();
        if (gap > 0) begin
            smp_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_ch.valid  <= 1'b1;
        smp_ch.sample <= s;
        @(posedge i_clk);
        while (!smp_ch.ready) @(posedge i_clk);
        pred = scale_sample(s);
        pending_scaled.push_back(typed ? typed_res : pred);
        n_accepted++;
    endtask

    // Drop valid and wait until every pending result has been taken
    task automatic drain_pipeline();
        smp_ch.valid <= 1'b0;
        while (pending_scaled.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input lcmas_pkg::t_cfg_reg r, input lcmas_pkg::t_cfg_data v);
        cfg_we   <= 1'b1;
        cfg_idx  <= r;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        // hold off the next write with the write enable low
        @(posedge i_clk);
        case (r)
            lcmas_pkg::REG_CAL_WEIGHT: cal_weight_q = int'(v);
            lcmas_pkg::REG_NEWTONS:    newtons_q    = int'(v);
            default: ;
        endcase
        n_writes++;
    endtask

    function automatic void field_check(input string name, input longint exp_v,
                                        input longint act_v);
        if (exp_v != act_v) begin
            if (n_errors < 30)
                $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, exp_v,
                         act_v);
            n_errors++;
        end
    endfunction

    // Compare a taken result with the oldest expectation
    function automatic void check_result();
        t_scaled e;
        if (pending_scaled.size() == 0) begin
            if (n_errors < 30)
                $display("%0t unexpected result: expected none, got avg %0d mass %0d force %0d",
                         $time, res_ch.average, res_ch.mass, res_ch.force_res);
            n_errors++;
        end else begin
            e = pending_scaled.pop_front();
            field_check("average", longint'(e.average), longint'(res_ch.average));
            field_check("mass", longint'(e.mass), longint'(res_ch.mass));
            field_check("force_res", longint'(e.force_res), longint'(res_ch.force_res));
        end
        n_checked++;
    endfunction

    // Result side: take items with random stalls and one long hold
    initial begin : drain_results
        int stall;
        bit held;
        stall = 0;
        held  = 1'b0;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (res_ch.valid && res_ch.ready) begin
                check_result();
                stall = pick_gap();
                if (!held && n_checked >= RX_HOLD_AT) begin
                    held  = 1'b1;
                    stall = RX_HOLD_CYCLES;
                end
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                stall--;
            end else begin
                res_ch.ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    // Sample side: reset, directed table, random phases, final drain
    initial begin : stimulus
        lcmas_pkg::t_cfg_data cal_v;
        lcmas_pkg::t_cfg_data grav_v;
        t_stim_row            row;
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= lcmas_pkg::REG_CAL_WEIGHT;
        cfg_data      <= '0;
        smp_ch.valid  <= 1'b0;
        smp_ch.sample <= '0;
        for (int i = 0; i < lcmas_pkg::AVG_LEN; i++) win_buf[i] = 0;
        win_sum      = 0;
        win_ptr      = 0;
        cal_weight_q = int'(lcmas_pkg::CAL_WEIGHT_RST);
        newtons_q    = int'(lcmas_pkg::NEWTONS_RST);
        no_idle      = 1'b0;
        n_accepted   = 0;
        n_checked    = 0;
        n_errors     = 0;
        n_writes     = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_table();
        foreach (stim_table[i]) begin
            row = stim_table[i];
            if (row.kind == ROW_CFG) begin
                drain_pipeline();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                push_sample(row.sample, row.typed, row.typed_res);
            end
        end

        // Random phases, each under its own register setting
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: begin cal_v = lcmas_pkg::CAL_WEIGHT_RST; grav_v = lcmas_pkg::NEWTONS_RST; end
                1: begin cal_v = 16'd0;          grav_v = 16'hFFFF;    end
                2: begin cal_v = 16'hFFFF;       grav_v = 16'd0;       end
                3: begin cal_v = 16'd1;          grav_v = 16'hFFFF;    end
                default: begin
                    cal_v  = lcmas_pkg::t_cfg_data'($urandom_range(0, 65535));
                    grav_v = lcmas_pkg::t_cfg_data'($urandom_range(0, 65535));
                    if (p == 6) cal_v = lcmas_pkg::t_cfg_data'($urandom_range(1, 16));
                end
            endcase
            drain_pipeline();
            write_reg(lcmas_pkg::REG_CAL_WEIGHT, cal_v);
            write_reg(lcmas_pkg::REG_NEWTONS, grav_v);
            no_idle = (p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // pause the sender until the block has emptied
                if (p == 7 && n == 40) drain_pipeline();
                push_sample(random_sample(), 1'b0, '0);
            end
        end
        no_idle = 1'b0;

        drain_pipeline();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Run covered %0d samples and %0d register writes; %0d results checked.",
                 n_accepted, n_writes, n_checked);
        $display("Directed extremes, zero divisor and %0d random phases with stalls done.",
                 N_PHASES);
        if (n_errors == 0 && pending_scaled.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/lcmas_pkg.sv
hdl/lcmas_if.sv
hdl/load_cell_moving_average_scaler.sv
dv/tb_load_cell_moving_average_scaler.sv
